>>> rtl/rfd_pkg.sv
// shared types, constants and codes for the rpc frame deframer
package rfd_pkg;

   // framing bytes and fixed overhead of a frame
   localparam logic [7:0]  START_BYTE  = 8'h02;
   localparam logic [7:0]  END_BYTE    = 8'h03;
   localparam logic [15:0] FIXED_BYTES = 16'd26;
   localparam logic [15:0] CKSUM_BYTES = 16'd4;

   // default length field width and queue depth
   localparam int LEN_BITS_DEF = 16;
   localparam int QUEUE_DEPTH  = 4;

   // configuration register reset values
   localparam logic [15:0] MAX_FRAME_LEN_RST  = 16'hFFFF;
   localparam logic [7:0]  MAX_REQ_ID_LEN_RST = 8'd50;
   localparam logic [15:0] MAX_NAME_LEN_RST   = 16'd512;
   localparam logic [15:0] MAX_INFO_LEN_RST   = 16'd512;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MAX_FRAME_LEN  = 2'd0,
      CSR_MAX_REQ_ID_LEN = 2'd1,
      CSR_MAX_NAME_LEN   = 2'd2,
      CSR_MAX_INFO_LEN   = 2'd3
   } csr_index_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_REQ_ID  = 3'd0,
      KIND_NAME    = 3'd1,
      KIND_INFO    = 3'd2,
      KIND_PAYLOAD = 3'd3,
      KIND_OK      = 3'd4,
      KIND_ERROR   = 3'd5
   } kind_type;

   // verdict status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_LEN   = 3'd1,
      ST_EMPTY_ID  = 3'd2,
      ST_TOO_LONG  = 3'd3,
      ST_PAST_END  = 3'd4,
      ST_NO_END    = 3'd5
   } status_type;

   // parser phases
   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_FLEN    = 4'd1,
      PH_RLEN    = 4'd2,
      PH_RID     = 4'd3,
      PH_NLEN    = 4'd4,
      PH_NAME    = 4'd5,
      PH_ECODE   = 4'd6,
      PH_ILEN    = 4'd7,
      PH_INFO    = 4'd8,
      PH_PAYLOAD = 4'd9,
      PH_CKSUM   = 4'd10,
      PH_END     = 4'd11
   } phase_type;

   // configuration limits
   typedef struct packed {
      logic [15:0] max_frame_len;
      logic [7:0]  max_req_id_len;
      logic [15:0] max_name_len;
      logic [15:0] max_info_len;
   } cfg_type;

   // classified byte in the queue between front and back
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_start;
      logic       is_end;
   } qitem_type;

   // one result item
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         data_byte;
      status_type         status;
      logic signed [31:0] error_code;
      logic [15:0]        frame_len;
      logic [15:0]        payload_len;
      logic               last;
   } rsp_type;

endpackage

>>> rtl/rfd_front.sv
// front end: accepts bytes, marks framing bytes and queues them for the parser
module rfd_front
   import rfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic      q_valid,
   input  logic      q_ready,
   output qitem_type q_item
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   qitem_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    push, pop;
   qitem_type               new_item;

   // classify the incoming byte
   always_comb begin
      new_item.rx_byte  = req_tdata;
      new_item.is_start = (req_tdata == START_BYTE);
      new_item.is_end   = (req_tdata == END_BYTE);
   end

   // queue handshakes and pointer updates
   always_comb begin
      req_tready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
      q_valid    = (count_ff != '0);
      q_item     = mem_ff[rd_ptr_ff];
      push       = req_tvalid && req_tready;
      pop        = q_valid && q_ready;
      wr_ptr_in  = push ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in  = pop ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = CNT_BITS'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_BITS'(count_ff - 1'b1);
      end
   end

   // pointer and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> rtl/rfd_parser.sv
// back end: frame parser state machine with registered result output
module rfd_parser
   import rfd_pkg::*;
#(
   parameter int LEN_BITS = LEN_BITS_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_valid,
   output logic      q_ready,
   input  qitem_type q_item,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp
);

   localparam logic [31:0] LEN_MAX = 32'((64'd1 << LEN_BITS) - 64'd1);

   phase_type   phase_ff, phase_in;
   logic [1:0]  wcnt_ff, wcnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] flen_ff, flen_in;
   // frame length minus fixed bytes minus text lengths taken so far
   logic [15:0] budget_ff, budget_in;
   logic [31:0] ecode_ff, ecode_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;

   logic        pop;
   logic [7:0]  b;
   logic [31:0] word;
   logic        word_done;
   logic [31:0] text_limit;
   logic        text_too_long;
   logic        text_past_end;
   logic [15:0] budget_after;
   logic        res_valid;
   rsp_type     res;

   assign b    = q_item.rx_byte;
   assign word = {acc_ff[23:0], b};

   // limit that applies to the text length word of this phase
   always_comb begin
      case (phase_ff)
         PH_RLEN: text_limit = {24'd0, cfg.max_req_id_len};
         PH_NLEN: text_limit = {16'd0, cfg.max_name_len};
         PH_ILEN: text_limit = {16'd0, cfg.max_info_len};
         default: text_limit = '0;
      endcase
      text_too_long = (word > text_limit) || (word > LEN_MAX);
      text_past_end = (word > {16'd0, budget_ff});
      budget_after  = budget_ff - word[15:0];
   end

   // phase update and result selection for one byte
   always_comb begin
      q_ready   = !out_valid_ff || rsp_ready;
      pop       = q_valid && q_ready;
      phase_in  = phase_ff;
      wcnt_in   = wcnt_ff;
      acc_in    = acc_ff;
      remain_in = remain_ff;
      flen_in   = flen_ff;
      budget_in = budget_ff;
      ecode_in  = ecode_ff;
      word_done = 1'b1;
      res_valid = 1'b0;
      res       = '0;

      if (pop) begin
         // gather big-endian length and code words
         if (phase_ff == PH_FLEN || phase_ff == PH_RLEN || phase_ff == PH_NLEN ||
             phase_ff == PH_ECODE || phase_ff == PH_ILEN) begin
            if (wcnt_ff != 2'd3) begin
               wcnt_in   = wcnt_ff + 2'd1;
               acc_in    = word;
               word_done = 1'b0;
            end else begin
               wcnt_in = 2'd0;
               acc_in  = '0;
            end
         end

         case (phase_ff)
            PH_HUNT: begin
               if (q_item.is_start) begin
                  phase_in  = PH_FLEN;
                  wcnt_in   = 2'd0;
                  acc_in    = '0;
                  remain_in = '0;
                  flen_in   = '0;
                  budget_in = '0;
                  ecode_in  = '0;
               end
            end
            PH_FLEN: begin
               if (word_done) begin
                  if (word < {16'd0, FIXED_BYTES} || word > {16'd0, cfg.max_frame_len} ||
                      word > LEN_MAX) begin
                     phase_in       = PH_HUNT;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.status     = ST_BAD_LEN;
                     res.error_code = ecode_ff;
                     res.frame_len  = (word > 32'h0000_FFFF) ? 16'hFFFF : word[15:0];
                     res.last       = 1'b1;
                  end else begin
                     flen_in   = word[15:0];
                     budget_in = word[15:0] - FIXED_BYTES;
                     phase_in  = PH_RLEN;
                  end
               end
            end
            PH_RLEN, PH_NLEN, PH_ILEN: begin
               if (word_done) begin
                  if ((phase_ff == PH_RLEN && word == '0) || text_too_long ||
                      text_past_end) begin
                     phase_in       = PH_HUNT;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ecode_ff;
                     res.frame_len  = flen_ff;
                     res.last       = 1'b1;
                     if (phase_ff == PH_RLEN && word == '0) begin
                        res.status = ST_EMPTY_ID;
                     end else if (text_too_long) begin
                        res.status = ST_TOO_LONG;
                     end else begin
                        res.status = ST_PAST_END;
                     end
                  end else begin
                     budget_in = budget_after;
                     remain_in = word[15:0];
                     case (phase_ff)
                        PH_RLEN: phase_in = PH_RID;
                        PH_NLEN: phase_in = (word == '0) ? PH_ECODE : PH_NAME;
                        default: begin
                           if (word != '0) begin
                              phase_in = PH_INFO;
                           end else if (budget_after == '0) begin
                              remain_in = CKSUM_BYTES;
                              phase_in  = PH_CKSUM;
                           end else begin
                              remain_in = budget_after;
                              phase_in  = PH_PAYLOAD;
                           end
                        end
                     endcase
                  end
               end
            end
            PH_ECODE: begin
               if (word_done) begin
                  ecode_in = word;
                  phase_in = PH_ILEN;
               end
            end
            PH_RID, PH_NAME, PH_INFO, PH_PAYLOAD: begin
               // content byte tagged by its section
               res_valid     = 1'b1;
               res.data_byte = b;
               remain_in     = remain_ff - 16'd1;
               case (phase_ff)
                  PH_RID:  res.kind = KIND_REQ_ID;
                  PH_NAME: res.kind = KIND_NAME;
                  PH_INFO: res.kind = KIND_INFO;
                  default: res.kind = KIND_PAYLOAD;
               endcase
               if (remain_ff == 16'd1) begin
                  case (phase_ff)
                     PH_RID:  phase_in = PH_NLEN;
                     PH_NAME: phase_in = PH_ECODE;
                     PH_INFO: begin
                        if (budget_ff == '0) begin
                           remain_in = CKSUM_BYTES;
                           phase_in  = PH_CKSUM;
                        end else begin
                           remain_in = budget_ff;
                           phase_in  = PH_PAYLOAD;
                        end
                     end
                     default: begin
                        remain_in = CKSUM_BYTES;
                        phase_in  = PH_CKSUM;
                     end
                  endcase
               end
            end
            PH_CKSUM: begin
               if (remain_ff <= 16'd1) begin
                  phase_in = PH_END;
               end else begin
                  remain_in = remain_ff - 16'd1;
               end
            end
            PH_END: begin
               phase_in       = PH_HUNT;
               res_valid      = 1'b1;
               res.error_code = ecode_ff;
               res.frame_len  = flen_ff;
               res.last       = 1'b1;
               if (!q_item.is_end) begin
                  res.kind   = KIND_ERROR;
                  res.status = ST_NO_END;
               end else begin
                  res.kind        = KIND_OK;
                  res.status      = ST_OK;
                  res.payload_len = budget_ff;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end

      out_valid_in = (out_valid_ff && !rsp_ready) || (pop && res_valid);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         wcnt_ff      <= '0;
         acc_ff       <= '0;
         remain_ff    <= '0;
         flen_ff      <= '0;
         budget_ff    <= '0;
         ecode_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wcnt_ff      <= wcnt_in;
         acc_ff       <= acc_in;
         remain_ff    <= remain_in;
         flen_ff      <= flen_in;
         budget_ff    <= budget_in;
         ecode_ff     <= ecode_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

>>> rtl/rpc_frame_deframer.sv
// top level of the rpc frame deframer: config registers, front queue and parser
//
// Receives a byte stream on req_* (one byte per item in req_tdata[7:0]) and
// hunts for start byte 0x02, then parses a length-prefixed frame. Each
// request id, name, info and payload byte leaves on rsp_* as one item tagged
// by rsp_tuser; header, checksum and framing bytes give no item. Each frame
// closes with one verdict item (ok or error) that has rsp_tlast high.
// Each item passes through the front queue and then the result register.
// Throughput: one byte per cycle while the receiver does not stall.
// The csr_* port writes the four length limits; write them only when idle.
// Reset (synchronous, active high) empties the queue, drops any partial frame,
// returns the parser to hunting and restores the default limits.
// When the receiver stalls, the result register holds its item, the parser
// stops and the four-entry queue absorbs bytes before req_tready drops.
module rpc_frame_deframer
   import rfd_pkg::*;
#(
   parameter int LEN_BITS = LEN_BITS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // data_byte, status, error_code, frame_len, payload_len
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type   cfg_ff;
   logic      q_valid;
   logic      q_ready;
   qitem_type q_item;
   rsp_type   rsp;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_frame_len  <= MAX_FRAME_LEN_RST;
         cfg_ff.max_req_id_len <= MAX_REQ_ID_LEN_RST;
         cfg_ff.max_name_len   <= MAX_NAME_LEN_RST;
         cfg_ff.max_info_len   <= MAX_INFO_LEN_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_FRAME_LEN:  cfg_ff.max_frame_len  <= csr_wdata;
            CSR_MAX_REQ_ID_LEN: cfg_ff.max_req_id_len <= csr_wdata[7:0];
            CSR_MAX_NAME_LEN:   cfg_ff.max_name_len   <= csr_wdata;
            CSR_MAX_INFO_LEN:   cfg_ff.max_info_len   <= csr_wdata;
            default: ;
         endcase
      end
   end

   rfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   rfd_parser #(
      .LEN_BITS (LEN_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack result fields, lowest bit first
   assign rsp_tdata = {5'd0, rsp.payload_len, rsp.frame_len, rsp.error_code,
                       rsp.status, rsp.data_byte};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule
